[sv/e2q_pkg.sv]
// e2q_pkg: shared constants and helpers for the euler to quaternion pipeline
// used by every module of the block; depends on nothing
package e2q_pkg;

  localparam int unsigned ANGLE_WIDTH_DEF  = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_ENTRIES     = 30;

  // cordic datapath: q.30 plus guard and sign bits
  localparam int unsigned CW = 34;
  // sine and cosine after rounding to q.20
  localparam int unsigned SW = 22;

  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [33:0]          PI_Q30   = 34'd3373259426;
  localparam logic signed [15:0]   Q14_ONE  = 16'sd16384;

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [SW-1:0] sw_t;

  // one cordic lane state: x, y and residual angle
  typedef struct packed {
    cw_t x;
    cw_t y;
    cw_t z;
  } lane_t;

  function automatic cw_t atan_q30(input int unsigned i);
    cw_t r;
    case (i)
      0: r = 34'sd843314857;   1: r = 34'sd497837829;
      2: r = 34'sd263043837;   3: r = 34'sd133525159;
      4: r = 34'sd67021687;    5: r = 34'sd33543516;
      6: r = 34'sd16775851;    7: r = 34'sd8388437;
      8: r = 34'sd4194283;     9: r = 34'sd2097149;
      default: r = cw_t'(64'sd1 << (30 - i));
    endcase
    return r;
  endfunction

endpackage

[sv/e2q_cordic_cell.sv]
// e2q_cordic_cell: one registered rotation step for the three angle lanes
// depends on e2q_pkg
module e2q_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  e2q_pkg::lane_t [2:0]      lane_i,
  output e2q_pkg::lane_t [2:0]      lane_o
);

  localparam e2q_pkg::cw_t Atan = e2q_pkg::atan_q30(STEP);

  e2q_pkg::lane_t [2:0] lane_d, lane_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!lane_i[k].z[e2q_pkg::CW-1]) begin
        lane_d[k].x = lane_i[k].x - (lane_i[k].y >>> STEP);
        lane_d[k].y = lane_i[k].y + (lane_i[k].x >>> STEP);
        lane_d[k].z = lane_i[k].z - Atan;
      end else begin
        lane_d[k].x = lane_i[k].x + (lane_i[k].y >>> STEP);
        lane_d[k].y = lane_i[k].y - (lane_i[k].x >>> STEP);
        lane_d[k].z = lane_i[k].z + Atan;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

[sv/e2q_combine.sv]
// e2q_combine: triple products and rounding to q1.14, three register stages
// depends on e2q_pkg
module e2q_combine (
  input  logic                clk_i,
  input  logic [2:0]          en_i,
  input  e2q_pkg::lane_t [2:0] lane_i,
  output logic signed [15:0]  quat_o [4]
);

  // index 0 yaw, 1 pitch, 2 roll
  e2q_pkg::sw_t s_d [3], c_d [3];
  e2q_pkg::sw_t s_q [3], c_q [3];
  logic signed [43:0] cc_q, ss_q, sc_q, cs_q;
  e2q_pkg::sw_t sy_q2, cy_q2;
  logic signed [65:0] p_q [8];

  function automatic e2q_pkg::sw_t rnd10(input e2q_pkg::cw_t v);
    e2q_pkg::cw_t t;
    t = v + e2q_pkg::cw_t'(512);
    return e2q_pkg::sw_t'(t >>> 10);
  endfunction

  function automatic logic signed [15:0] q14(input logic signed [66:0] v);
    logic signed [66:0] t;
    logic signed [20:0] r;
    t = v + (67'sd1 <<< 45);
    r = 21'(t >>> 46);
    if (r > 21'sd16384) return e2q_pkg::Q14_ONE;
    if (r < -21'sd16384) return -e2q_pkg::Q14_ONE;
    return 16'(r);
  endfunction

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_d[k] = rnd10(lane_i[k].x);
      s_d[k] = rnd10(lane_i[k].y);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s_q <= s_d;
      c_q <= c_d;
    end
    if (en_i[1]) begin
      cc_q  <= c_q[2] * c_q[1];
      ss_q  <= s_q[2] * s_q[1];
      sc_q  <= s_q[2] * c_q[1];
      cs_q  <= c_q[2] * s_q[1];
      sy_q2 <= s_q[0];
      cy_q2 <= c_q[0];
    end
    if (en_i[2]) begin
      p_q[0] <= cc_q * cy_q2;  p_q[1] <= ss_q * sy_q2;
      p_q[2] <= sc_q * cy_q2;  p_q[3] <= cs_q * sy_q2;
      p_q[4] <= cs_q * cy_q2;  p_q[5] <= sc_q * sy_q2;
      p_q[6] <= cc_q * sy_q2;  p_q[7] <= ss_q * cy_q2;
    end
  end

  assign quat_o[0] = q14(67'(p_q[0]) + 67'(p_q[1]));
  assign quat_o[1] = q14(67'(p_q[2]) - 67'(p_q[3]));
  assign quat_o[2] = q14(67'(p_q[4]) + 67'(p_q[5]));
  assign quat_o[3] = q14(67'(p_q[6]) - 67'(p_q[7]));

endmodule

[sv/euler_to_quaternion_top.sv]
// euler to quaternion: angles clamped and halved, a chain of cordic cells,
// then triple products in a three-stage combine; output register follows.
// registers between an accepted input beat and its result (steps capped at 30):
// one register per cell, three in combine, one output;
// one beat per cycle sustained, the pipeline advances whenever the output
// register is free or being taken. reset clears the valid flags only.
module euler_to_quaternion_top #(
  parameter int unsigned ANGLE_WIDTH  = e2q_pkg::ANGLE_WIDTH_DEF,
  parameter int unsigned CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // yaw_angle, pitch_angle, roll_angle from bit 0 up, zero fill to bytes
  input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // quat_w, quat_x, quat_y, quat_z from bit 0 up
  output logic [63:0]              m_axis_tdata
);

  localparam int unsigned Steps = (CORDIC_STEPS > e2q_pkg::ATAN_ENTRIES) ?
                                  e2q_pkg::ATAN_ENTRIES : CORDIC_STEPS;
  localparam int unsigned Depth = Steps + 3;
  localparam longint Lim = (longint'(e2q_pkg::PI_Q30) + (64'sd1 << (32 - ANGLE_WIDTH)))
                           >>> (33 - ANGLE_WIDTH);

  logic [Depth-1:0] vld_q;
  logic             out_vld_q;
  logic [63:0]      out_data_q;
  logic             adv;
  logic signed [15:0] quat [4];
  e2q_pkg::lane_t [2:0] lane_in;
  e2q_pkg::lane_t [2:0] chain [Steps+1];

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // clamp and scale each angle to a q.30 half angle
  always_comb begin
    logic signed [ANGLE_WIDTH-1:0] a;
    logic signed [e2q_pkg::CW-1:0] ae;
    for (int k = 0; k < 3; k++) begin
      a  = s_axis_tdata[k*ANGLE_WIDTH +: ANGLE_WIDTH];
      ae = e2q_pkg::CW'(a);
      if (ae > e2q_pkg::CW'(Lim)) ae = e2q_pkg::CW'(Lim);
      if (ae < -e2q_pkg::CW'(Lim)) ae = -e2q_pkg::CW'(Lim);
      lane_in[k].x = e2q_pkg::GAIN_Q30;
      lane_in[k].y = '0;
      lane_in[k].z = ae <<< (32 - ANGLE_WIDTH);
    end
  end

  assign chain[0] = lane_in;

  for (genvar g = 0; g < Steps; g++) begin : g_cell
    e2q_cordic_cell #(.STEP(g)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .lane_i (chain[g]),
      .lane_o (chain[g+1])
    );
  end

  e2q_combine u_combine (
    .clk_i  (clk_i),
    .en_i   ({3{adv}}),
    .lane_i (chain[Steps]),
    .quat_o (quat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[Depth-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {quat[3], quat[2], quat[1], quat[0]};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[dv/euler_to_quaternion_top_tb.sv]
// testbench for euler_to_quaternion_top: random and corner angle beats checked
// against an in-bench fixed-point cordic predictor; depends on e2q_pkg and the dut
`timescale 1ns / 1ps

module euler_to_quaternion_top_tb;

  localparam int unsigned AW = 16;
  localparam int unsigned STEPS = 16;
  localparam int unsigned LAT = STEPS + 5;
  localparam int unsigned TDW = ((3*AW+7)/8)*8;
  localparam int unsigned NUM_RAND = 950;
  localparam longint CYCLE_LIMIT = 200000;
  localparam longint ANG_LIM = 25736;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic signed [15:0] w;
  } quat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [TDW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  euler_to_quaternion_top #(.ANGLE_WIDTH(AW), .CORDIC_STEPS(STEPS)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [TDW-1:0] angle_q[$];
  quat_t quat_exp_q[$];
  int unsigned err_cnt = 0;
  bit stim_done = 0;
  longint cycle_cnt = 0;

  function automatic void add_angle(logic [TDW-1:0] d);
    angle_q = {angle_q, d};
  endfunction

  function automatic void add_exp(quat_t q);
    quat_exp_q = {quat_exp_q, q};
  endfunction

  function automatic longint fl_shift(longint v, int unsigned s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int unsigned s);
    return (v + (64'sd1 << (s - 1))) >>> s;
  endfunction

  function automatic longint atan_val(int unsigned i);
    case (i)
      0: return 843314857;  1: return 497837829;  2: return 263043837;
      3: return 133525159;  4: return 67021687;   5: return 33543516;
      6: return 16775851;   7: return 8388437;    8: return 4194283;
      9: return 2097149;
      default: return 64'sd1 << (30 - i);
    endcase
  endfunction

  // clamp to pi and scale to a q.30 half angle
  function automatic longint half_angle(logic [AW-1:0] raw);
    longint a;
    a = longint'($signed(raw));
    if (a > ANG_LIM) a = ANG_LIM;
    if (a < -ANG_LIM) a = -ANG_LIM;
    return a * (64'sd1 << (32 - AW));
  endfunction

  task automatic cordic_sincos(input longint z0, output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = 652032874; y = 0; z = z0;
    for (int unsigned i = 0; i < STEPS && i < 30; i++) begin
      dx = fl_shift(y, i);
      dy = fl_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_val(i);
      end else begin
        x += dx; y -= dy; z += atan_val(i);
      end
    end
    c = rnd_shift(x, 10);
    s = rnd_shift(y, 10);
  endtask

  function automatic logic signed [15:0] sat_q14(longint v);
    longint r;
    r = rnd_shift(v, 46);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return 16'(r);
  endfunction

  task automatic predict_quat(input logic [TDW-1:0] d, output quat_t q);
    longint sy, cy, sp, cp, sr, cr;
    cordic_sincos(half_angle(d[AW-1:0]), sy, cy);
    cordic_sincos(half_angle(d[2*AW-1:AW]), sp, cp);
    cordic_sincos(half_angle(d[3*AW-1:2*AW]), sr, cr);
    q.w = sat_q14(cr*cp*cy + sr*sp*sy);
    q.x = sat_q14(sr*cp*cy - cr*sp*sy);
    q.y = sat_q14(cr*sp*cy + sr*cp*sy);
    q.z = sat_q14(cr*cp*sy - sr*sp*cy);
  endtask

  function automatic logic [AW-1:0] rand_angle();
    case ($urandom_range(0, 9))
      0: return AW'($urandom);
      1: return AW'(ANG_LIM - 64 + $urandom_range(0, 128));
      2: return AW'(-ANG_LIM + 64 - $urandom_range(0, 128));
      default: return AW'($urandom_range(0, 2*ANG_LIM) - ANG_LIM);
    endcase
  endfunction

  // driver
  int unsigned tx_gap = 0;
  always @(posedge clk_i) begin
    quat_t q;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_quat(s_axis_tdata, q);
        add_exp(q);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          s_axis_tvalid <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (angle_q.size() > 0) begin
          s_axis_tdata <= angle_q.pop_front();
          s_axis_tvalid <= 1'b1;
          tx_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls; one long hold-off early on fills the pipeline
  int unsigned rx_hold = 0;
  longint rx_beats = 0;
  bit long_hold_done = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!long_hold_done && cycle_cnt == 300) begin
        long_hold_done <= 1;
        rx_hold <= 200;
        m_axis_tready <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tready && m_axis_tvalid && $urandom_range(0, 3) == 0) begin
        rx_hold <= $urandom_range(0, 6);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    quat_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (quat_exp_q.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        err_cnt++;
      end else begin
        want = quat_exp_q.pop_front();
        if (got.w !== want.w)
          $display("%0t: quat_w exp %0d got %0d", $time, want.w, got.w);
        if (got.x !== want.x)
          $display("%0t: quat_x exp %0d got %0d", $time, want.x, got.x);
        if (got.y !== want.y)
          $display("%0t: quat_y exp %0d got %0d", $time, want.y, got.y);
        if (got.z !== want.z)
          $display("%0t: quat_z exp %0d got %0d", $time, want.z, got.z);
        if (got !== want) err_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("euler_to_quaternion_top_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [TDW-1:0] pack_angles(longint yw, longint pt, longint rl);
    logic [TDW-1:0] d;
    d = '0;
    d[AW-1:0] = AW'(yw);
    d[2*AW-1:AW] = AW'(pt);
    d[3*AW-1:2*AW] = AW'(rl);
    return d;
  endfunction

  initial begin
    longint corners[7] = '{0, ANG_LIM, -ANG_LIM, 32767, -32768, 12868, -12868};
    // directed: zero, pi, beyond pi (clamped), pi/2, extremes of the field
    foreach (corners[i]) add_angle(pack_angles(corners[i], 0, 0));
    foreach (corners[i]) add_angle(pack_angles(0, corners[i], 0));
    foreach (corners[i]) add_angle(pack_angles(0, 0, corners[i]));
    add_angle(pack_angles(32767, 32767, 32767));
    add_angle(pack_angles(-32768, -32768, -32768));
    add_angle(pack_angles(12868, 12868, -12868));
    for (int i = 0; i < NUM_RAND; i++)
      add_angle(pack_angles(rand_angle(), rand_angle(), rand_angle()));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (angle_q.size() == 0 && !(s_axis_tvalid && !s_axis_tready));
    @(posedge clk_i);
    wait (quat_exp_q.size() == 0);
    repeat (LAT + 10) @(posedge clk_i);
    if (err_cnt == 0 && quat_exp_q.size() == 0)
      $display("euler_to_quaternion_top_tb: PASS");
    else
      $display("euler_to_quaternion_top_tb: FAIL");
    $finish;
  end

endmodule

[euler_to_quaternion_top.f]
sv/e2q_pkg.sv
sv/e2q_cordic_cell.sv
sv/e2q_combine.sv
sv/euler_to_quaternion_top.sv
dv/euler_to_quaternion_top_tb.sv
